>>> rtl/epd_pkg.sv
// Package for the event packet deframer: payload types, codes, constants and control structs.
package epd_pkg;

    // Sync words as seen on the raw stream
    localparam logic [31:0] SYNC_DIG  = 32'hAAAA_AAAA;
    localparam logic [31:0] SYNC_TRIG = 32'hAAAA_0000;

    // Trigger record sizes
    localparam int TRIG_IN_WORDS    = 16;
    localparam int TRIG_OUT_WORDS   = 18;
    localparam int TRIG_STORE_DEPTH = 16;
    localparam int TRIG_STORE_AW    = $clog2(TRIG_STORE_DEPTH);

    // Word counter covers the trigger record length and the skip length
    localparam int WC_W  = $clog2(TRIG_IN_WORDS + 1);
    localparam int IDX_W = $clog2(TRIG_OUT_WORDS);

    // Header fields of rebuilt trigger packets
    localparam logic [11:0] TRIG_BOARD = 12'd99;
    localparam logic [3:0]  TRIG_ID    = 4'hE;
    localparam logic [31:0] TRIG_FLAGS = 32'h0C00_0000;  // 3 << 26

    // Channel handling in digitizer headers
    localparam logic [3:0] CH_SKIP_MIN = 4'd10;
    localparam logic [3:0] CH_STOP     = 4'hD;
    localparam int         SKIP_WORDS  = 4;

    localparam logic [1:0] KIND_DIG    = 2'd0;
    localparam logic [1:0] KIND_TRIG   = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    localparam logic [2:0] ST_GOOD     = 3'd0;
    localparam logic [2:0] ST_RUN_DONE = 3'd1;
    localparam logic [2:0] ST_DIG_INC  = 3'd2;
    localparam logic [2:0] ST_TRIG_INC = 3'd3;
    localparam logic [2:0] ST_UNKNOWN  = 3'd4;

    typedef struct packed {
        logic [31:0] word;
        logic        block_end;
    } in_item_t;

    typedef struct packed {
        logic [31:0] out_word;
        logic [1:0]  kind;
        logic [11:0] board;
        logic [3:0]  channel;
        logic        packet_last;
        logic [2:0]  status;
    } out_item_t;

    typedef enum logic [5:0] {
        MODE_HUNT  = 6'b000001,
        MODE_DHEAD = 6'b000010,
        MODE_DBODY = 6'b000100,
        MODE_SKIP  = 6'b001000,
        MODE_TRIG  = 6'b010000,
        MODE_BAD   = 6'b100000
    } parse_mode_t;

    // Controller -> datapath
    typedef struct packed {
        logic capture;
        logic step;
        logic emit_hdr2;
        logic trig_read;
        logic trig_emit;
        logic emit_status;
    } epd_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic can_load;
        logic step_emits;
        logic step_hdr2;
        logic step_trig;
        logic item_end;
        logic trig_last;
    } epd_stat_t;

endpackage

>>> rtl/epd_datapath.sv
// Datapath of the deframer: parse registers, trigger store, word builder and output register.
module epd_datapath
    import epd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  in_item_t  in_data,
    input  epd_cmd_t  cmd,
    output epd_stat_t stat,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    function automatic logic [31:0] swap32(input logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    function automatic parse_mode_t begin_mode(input logic [31:0] w);
        parse_mode_t m;
        if (w == SYNC_DIG) begin
            m = MODE_DHEAD;
        end else if (w == SYNC_TRIG) begin
            m = MODE_TRIG;
        end else begin
            m = MODE_BAD;
        end
        return m;
    endfunction

    parse_mode_t             mode_reg, mode_next;
    logic [WC_W-1:0]         wc_reg, wc_next;
    logic [10:0]             pw_reg, pw_next;
    logic [11:0]             held_board_reg, held_board_next;
    logic [3:0]              held_ch_reg, held_ch_next;
    logic                    run_done_reg, run_done_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic                    out_valid_reg, out_valid_next;
    out_item_t               out_reg, out_next;
    logic [31:0]             word_reg, word_next;
    logic                    end_reg, end_next;

    logic [31:0]             trig_mem [TRIG_STORE_DEPTH];
    logic [31:0]             rd_a_reg, rd_b_reg;
    logic [TRIG_STORE_AW-1:0] addr_a, addr_b;
    logic                    mem_we;

    logic [31:0]             hdr;
    logic [3:0]              hdr_ch;
    logic [11:0]             hdr_board;
    logic [10:0]             hdr_len;
    logic                    hdr_keep;
    logic [WC_W-1:0]         wc_inc;
    logic [10:0]             pw_dec;
    logic                    load;
    logic [31:0]             trig_word;
    logic [31:0]             hi_part;
    logic [2:0]              blk_status;
    logic                    trig_last;

    assign hdr       = swap32(word_reg);
    assign hdr_ch    = hdr[3:0];
    assign hdr_board = hdr[15:4];
    assign hdr_len   = hdr[26:16];
    assign hdr_keep  = hdr_ch < CH_SKIP_MIN;
    assign wc_inc    = wc_reg + 1'b1;
    assign pw_dec    = pw_reg - 1'b1;
    assign trig_last = idx_reg == IDX_W'(TRIG_OUT_WORDS - 1);

    assign stat.can_load   = !out_valid_reg || out_ready;
    assign stat.step_emits = !run_done_reg
                             && (((mode_reg == MODE_DHEAD) && hdr_keep)
                                 || (mode_reg == MODE_DBODY));
    assign stat.step_hdr2  = !run_done_reg && (mode_reg == MODE_DHEAD) && hdr_keep
                             && (hdr_len != 11'd0);
    assign stat.step_trig  = !run_done_reg && (mode_reg == MODE_TRIG)
                             && (wc_inc >= WC_W'(TRIG_IN_WORDS));
    assign stat.item_end   = end_reg;
    assign stat.trig_last  = trig_last;

    // Store entries feeding each rebuilt word: addr_a gives the upper half
    always_comb
    begin
        addr_a = '0;
        addr_b = '0;
        if (idx_reg == IDX_W'(2)) begin
            addr_a = TRIG_STORE_AW'(3);
            addr_b = TRIG_STORE_AW'(4);
        end else if (idx_reg == IDX_W'(3)) begin
            addr_b = TRIG_STORE_AW'(2);
        end else if (idx_reg == IDX_W'(4)) begin
            addr_a = TRIG_STORE_AW'(1);
            addr_b = TRIG_STORE_AW'(5);
        end else if ((idx_reg >= IDX_W'(5)) && (idx_reg <= IDX_W'(9))) begin
            addr_a = TRIG_STORE_AW'({idx_reg[3:0], 1'b0} - 5'd4);
            addr_b = TRIG_STORE_AW'({idx_reg[3:0], 1'b0} - 5'd3);
        end
    end

    assign hi_part = {rd_a_reg[15:0], 16'h0000};

    always_comb
    begin
        if (idx_reg == IDX_W'(0)) begin
            trig_word = SYNC_DIG;
        end else if (idx_reg == IDX_W'(1)) begin
            trig_word = {5'b0, 11'(TRIG_OUT_WORDS), TRIG_BOARD, 4'b0};
        end else if (idx_reg == IDX_W'(2)) begin
            trig_word = hi_part | rd_b_reg;
        end else if (idx_reg == IDX_W'(3)) begin
            trig_word = rd_b_reg | {12'h000, TRIG_ID, 16'h0000} | TRIG_FLAGS;
        end else if (idx_reg <= IDX_W'(9)) begin
            trig_word = hi_part + rd_b_reg;   // carries into the upper half
        end else begin
            trig_word = '0;
        end
    end

    always_comb
    begin
        if (run_done_reg) begin
            blk_status = ST_RUN_DONE;
        end else if ((mode_reg == MODE_DHEAD) || (mode_reg == MODE_DBODY)) begin
            blk_status = ST_DIG_INC;
        end else if (mode_reg == MODE_TRIG) begin
            blk_status = ST_TRIG_INC;
        end else if (mode_reg == MODE_BAD) begin
            blk_status = ST_UNKNOWN;
        end else begin
            blk_status = ST_GOOD;
        end
    end

    always_comb
    begin
        mode_next       = mode_reg;
        wc_next         = wc_reg;
        pw_next         = pw_reg;
        held_board_next = held_board_reg;
        held_ch_next    = held_ch_reg;
        run_done_next   = run_done_reg;
        idx_next        = idx_reg;
        out_next        = out_reg;
        load            = 1'b0;
        mem_we          = 1'b0;
        word_next       = cmd.capture ? in_data.word : word_reg;
        end_next        = cmd.capture ? in_data.block_end : end_reg;

        if (cmd.step && !run_done_reg) begin
            unique case (mode_reg)
                MODE_HUNT:
                begin
                    mode_next = begin_mode(word_reg);
                    if (word_reg == SYNC_TRIG) begin
                        wc_next = WC_W'(1);  // entry 0 is never written and its contents are never used
                    end
                end
                MODE_DHEAD:
                begin
                    if (!hdr_keep) begin
                        if (hdr_ch == CH_STOP) begin
                            run_done_next = 1'b1;
                            mode_next     = MODE_HUNT;
                        end else begin
                            mode_next = MODE_SKIP;
                            wc_next   = WC_W'(2);
                        end
                    end else begin
                        held_board_next = hdr_board;
                        held_ch_next    = hdr_ch;
                        load            = 1'b1;
                        out_next        = '{out_word: SYNC_DIG, kind: KIND_DIG,
                                            board: hdr_board, channel: hdr_ch,
                                            packet_last: hdr_len == 11'd0,
                                            status: ST_GOOD};
                        if (hdr_len == 11'd0) begin
                            // sync-only packet: this word opens the next item
                            mode_next = begin_mode(word_reg);
                            if (word_reg == SYNC_TRIG) begin
                                wc_next = WC_W'(1);
                            end
                        end else begin
                            pw_next   = hdr_len - 11'd1;
                            mode_next = (hdr_len > 11'd1) ? MODE_DBODY : MODE_HUNT;
                        end
                    end
                end
                MODE_DBODY:
                begin
                    pw_next  = pw_dec;
                    load     = 1'b1;
                    out_next = '{out_word: word_reg, kind: KIND_DIG,
                                 board: held_board_reg, channel: held_ch_reg,
                                 packet_last: pw_dec == 11'd0, status: ST_GOOD};
                    if (pw_dec == 11'd0) begin
                        mode_next = MODE_HUNT;
                    end
                end
                MODE_SKIP:
                begin
                    wc_next = wc_inc;
                    if (wc_inc >= WC_W'(SKIP_WORDS)) begin
                        mode_next = MODE_HUNT;
                    end
                end
                MODE_TRIG:
                begin
                    mem_we  = wc_reg < WC_W'(TRIG_STORE_DEPTH);
                    wc_next = wc_inc;
                    if (wc_inc >= WC_W'(TRIG_IN_WORDS)) begin
                        mode_next = MODE_HUNT;
                        wc_next   = '0;
                    end
                end
                MODE_BAD:
                begin
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.emit_hdr2) begin
            load     = 1'b1;
            out_next = '{out_word: word_reg, kind: KIND_DIG,
                         board: held_board_reg, channel: held_ch_reg,
                         packet_last: pw_reg == 11'd0, status: ST_GOOD};
        end

        if (cmd.trig_emit) begin
            load     = 1'b1;
            out_next = '{out_word: trig_word, kind: KIND_TRIG, board: TRIG_BOARD,
                         channel: 4'd0, packet_last: trig_last, status: ST_GOOD};
            idx_next = trig_last ? '0 : idx_reg + 1'b1;
        end

        if (cmd.emit_status) begin
            load      = 1'b1;
            out_next  = '{out_word: 32'd0, kind: KIND_STATUS, board: 12'd0,
                          channel: 4'd0, packet_last: 1'b0, status: blk_status};
            mode_next = MODE_HUNT;
            wc_next   = '0;
            pw_next   = '0;
        end

        if (load) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg       <= MODE_HUNT;
            wc_reg         <= '0;
            pw_reg         <= '0;
            held_board_reg <= '0;
            held_ch_reg    <= '0;
            run_done_reg   <= 1'b0;
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            mode_reg       <= mode_next;
            wc_reg         <= wc_next;
            pw_reg         <= pw_next;
            held_board_reg <= held_board_next;
            held_ch_reg    <= held_ch_next;
            run_done_reg   <= run_done_next;
            idx_reg        <= idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        word_reg <= word_next;
        end_reg  <= end_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we) begin
            trig_mem[wc_reg[TRIG_STORE_AW-1:0]] <= hdr;
        end
        if (cmd.trig_read) begin
            rd_a_reg <= trig_mem[addr_a];
            rd_b_reg <= trig_mem[addr_b];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

>>> rtl/epd_controller.sv
// Controller of the deframer: sequences capture, parse step and result emission per word.
module epd_controller
    import epd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  epd_stat_t stat,
    output epd_cmd_t  cmd
);

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_PARSE    = 6'b000010,
        S_HDR2     = 6'b000100,
        S_TRIG_RD  = 6'b001000,
        S_TRIG_OUT = 6'b010000,
        S_STATUS   = 6'b100000
    } ctrl_state_t;

    ctrl_state_t state_reg, state_next;
    ctrl_state_t after_item;

    assign after_item = stat.item_end ? S_STATUS : S_IDLE;
    assign in_ready   = state_reg == S_IDLE;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_PARSE;
                end
            end
            S_PARSE:
            begin
                // hold the step until the output register can take its result
                if (!stat.step_emits || stat.can_load) begin
                    cmd.step = 1'b1;
                    priority if (stat.step_hdr2) begin
                        state_next = S_HDR2;
                    end else if (stat.step_trig) begin
                        state_next = S_TRIG_RD;
                    end else begin
                        state_next = after_item;
                    end
                end
            end
            S_HDR2:
            begin
                if (stat.can_load) begin
                    cmd.emit_hdr2 = 1'b1;
                    state_next    = after_item;
                end
            end
            S_TRIG_RD:
            begin
                cmd.trig_read = 1'b1;
                state_next    = S_TRIG_OUT;
            end
            S_TRIG_OUT:
            begin
                if (stat.can_load) begin
                    cmd.trig_emit = 1'b1;
                    state_next    = stat.trig_last ? after_item : S_TRIG_RD;
                end
            end
            S_STATUS:
            begin
                if (stat.can_load) begin
                    cmd.emit_status = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/event_packet_deframer.sv
// Top level of the event packet deframer: controller plus datapath.
//
// Input channel (in_valid/in_ready/in_data) takes one 32-bit received word per
// transaction, with block_end set on the last word of a block. Output channel
// (out_valid/out_ready/out_data) gives tagged packet words and one status per block.
// Digitizer packets are passed through with board/channel tags; trigger records
// are collected in a 16-entry store and rebuilt as TRIG_OUT_WORDS-word packets.
// A word is accepted in the idle state and then parsed in the parse state; a parse
// step that gives a result waits until the output register can take it. A digitizer
// header word that emits both sync and header loads the header in a further state.
// The word that completes a trigger record emits TRIG_OUT_WORDS rebuilt words, each
// through a registered store read and then a load of the output register. A block
// end adds a status result. Results leave through one output register, so
// a word can be accepted while the previous result still waits to be taken.
// Reset clears the parser to sync hunt and drops any pending result; the
// trigger store keeps no reset value. When the receiver stalls, the result
// being offered holds, and parsing pauses at the next result to be loaded.
module event_packet_deframer
    import epd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    epd_cmd_t  cmd;
    epd_stat_t stat;

    epd_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    epd_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

>>> rtl/epd_checker.sv
// Port-level assertions for the event packet deframer, bound to the top level.
module epd_checker
    import epd_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_data
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output changed while stalled");

    // one word in flight: busy right after a transaction
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted back to back");

    a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.kind == KIND_STATUS) |->
            (out_data.out_word == 32'd0) && (out_data.board == 12'd0)
            && (out_data.channel == 4'd0) && !out_data.packet_last)
        else $error("status result carries packet fields");

    a_trig_tags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.kind == KIND_TRIG) |->
            (out_data.board == TRIG_BOARD) && (out_data.channel == 4'd0))
        else $error("trigger word with wrong tags");

    a_word_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.kind != KIND_STATUS) |->
            (out_data.status == ST_GOOD) && (out_data.kind != 2'd3))
        else $error("packet word with status set");

endmodule

bind event_packet_deframer epd_checker u_epd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
